// File: sv/rfg_pkg.sv
package rfg_pkg;

  localparam int CoordW = 7;
  localparam int CountW = 8;
  localparam int ValueW = 31;

  localparam logic [CountW-1:0] CountRst = 8'd128;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_FILL = 2'd1,
    MODE_READ = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_idx_e;

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  typedef logic [CoordW-1:0] coord_t;

  // walker control and status
  typedef struct packed {
    logic start;
    logic step;
  } walk_ctrl_t;

  typedef struct packed {
    logic last;
  } walk_stat_t;

endpackage

// File: sv/rfg_ram.sv
module rfg_ram #(
  parameter int AW = 14,
  parameter int DW = 31
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data only moves on a read, so it holds while a result waits
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/rfg_walk.sv
module rfg_walk import rfg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  walk_ctrl_t ctrl_i,
  input  coord_t     row_first_i,
  input  coord_t     col_first_i,
  input  coord_t     row_last_i,
  input  coord_t     col_last_i,
  output coord_t     row_o,
  output coord_t     col_o,
  output walk_stat_t stat_o
);

  coord_t row_q, row_d;
  coord_t col_q, col_d;
  logic   col_end;

  assign col_end = (col_q == col_last_i);

  // raster order, left to right, top to bottom
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (ctrl_i.start) begin
      row_d = row_first_i;
      col_d = col_first_i;
    end else if (ctrl_i.step) begin
      if (col_end) begin
        col_d = col_first_i;
        row_d = row_q + coord_t'(1);
      end else begin
        col_d = col_q + coord_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign row_o       = row_q;
  assign col_o       = col_q;
  assign stat_o.last = col_end && (row_q == row_last_i);

endmodule

// File: sv/rectangle_fill_grid_store_top.sv
// Flow: a load, read or rejected item goes from accept through ST_RESP into the
// output register; a fill that writes goes through ST_FILL, where the row/column
// walker writes one cell a cycle, then through ST_RESP. Throughput: one item in
// flight, none taken until its result is registered; a held result stalls accept.
// Reset: asynchronous, active low; counts return to 128, grid contents stay
// undefined until written.
module rectangle_fill_grid_store_top import rfg_pkg::*; #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [6:0] row_first, [13:7] col_first, [20:14] row_last, [27:21] col_last,
  // [58:28] new_value, rest zero
  input  logic [63:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser_i,
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [30:0] read_value, [31] zero
  output logic [31:0] m_axis_tdata_o,
  // [0] status
  output logic [0:0]  m_axis_tuser_o
);

  // index widths into the grid; row and column bits are concatenated
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;
  localparam int XW = (RW > CoordW) ? ((RW > CW) ? RW : CW)
                                    : ((CW > CoordW) ? CW : CoordW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RESP
  } state_e;

  state_e state_q;

  // configuration
  logic [CountW-1:0] row_count_q, col_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CountRst;
      col_count_q <= CountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_COUNT: row_count_q <= cfg_data_i;
        CFG_COL_COUNT: col_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input item fields
  mode_e              in_mode;
  coord_t             in_r0, in_c0, in_r1, in_c1;
  logic [ValueW-1:0]  in_value;

  assign in_mode  = mode_e'(s_axis_tuser_i);
  assign in_r0    = s_axis_tdata_i[6:0];
  assign in_c0    = s_axis_tdata_i[13:7];
  assign in_r1    = s_axis_tdata_i[20:14];
  assign in_c1    = s_axis_tdata_i[27:21];
  assign in_value = s_axis_tdata_i[58:28];

  logic accept;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // in range: below the count register and below the grid size
  function automatic logic coord_in(coord_t c, logic [CountW-1:0] cnt, int lim);
    return ({1'b0, c} < cnt) && (int'(c) < lim);
  endfunction

  logic first_ok, last_ok, reversed;
  assign first_ok = coord_in(in_r0, row_count_q, MAX_ROWS) &&
                    coord_in(in_c0, col_count_q, MAX_COLS);
  assign last_ok  = coord_in(in_r1, row_count_q, MAX_ROWS) &&
                    coord_in(in_c1, col_count_q, MAX_COLS);
  assign reversed = (in_r0 > in_r1) || (in_c0 > in_c1);

  logic in_status, do_load, do_fill, do_read;
  always_comb begin
    in_status = StatusErr;
    do_load   = 1'b0;
    do_fill   = 1'b0;
    do_read   = 1'b0;
    case (in_mode)
      MODE_LOAD: begin
        in_status = first_ok ? StatusOk : StatusErr;
        do_load   = first_ok;
      end
      MODE_FILL: begin
        in_status = (first_ok && last_ok) ? StatusOk : StatusErr;
        do_fill   = first_ok && last_ok && !reversed;
      end
      MODE_READ: begin
        in_status = first_ok ? StatusOk : StatusErr;
        do_read   = first_ok;
      end
      default: in_status = StatusErr;
    endcase
  end

  // latched item, held for the fill walk and the result
  coord_t            r0_q, c0_q, r1_q, c1_q;
  logic [ValueW-1:0] value_q;
  logic              status_q, is_read_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r0_q      <= in_r0;
      c0_q      <= in_c0;
      r1_q      <= in_r1;
      c1_q      <= in_c1;
      value_q   <= in_value;
      status_q  <= in_status;
      is_read_q <= do_read;
    end
  end

  // rectangle walker
  walk_ctrl_t walk_ctrl;
  walk_stat_t walk_stat;
  coord_t     walk_row, walk_col;
  coord_t     walk_r0, walk_c0;

  assign walk_ctrl.start = accept && do_fill;
  assign walk_ctrl.step  = (state_q == ST_FILL);

  // first cell comes straight from the input on the accept edge
  assign walk_r0 = walk_ctrl.start ? in_r0 : r0_q;
  assign walk_c0 = walk_ctrl.start ? in_c0 : c0_q;

  rfg_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (walk_ctrl),
    .row_first_i (walk_r0),
    .col_first_i (walk_c0),
    .row_last_i  (r1_q),
    .col_last_i  (c1_q),
    .row_o       (walk_row),
    .col_o       (walk_col),
    .stat_o      (walk_stat)
  );

  // grid addresses
  logic [AW-1:0] in_addr, walk_addr;
  assign in_addr   = {RW'(XW'(in_r0)), CW'(XW'(in_c0))};
  assign walk_addr = {RW'(XW'(walk_row)), CW'(XW'(walk_col))};

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ValueW-1:0] mem_wdata, mem_rdata;

  // loads write on the accept edge; the fill walk owns the port otherwise
  assign mem_we    = (accept && do_load) || (state_q == ST_FILL);
  assign mem_waddr = (state_q == ST_FILL) ? walk_addr : in_addr;
  assign mem_wdata = (state_q == ST_FILL) ? value_q : in_value;

  rfg_ram #(
    .AW (AW),
    .DW (ValueW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept && do_read),
    .raddr_i (in_addr),
    .rdata_o (mem_rdata)
  );

  // sequencer and output register
  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_status_q;
  logic              out_free;

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= StatusOk;
    end else begin
      // a new result takes precedence over draining the old one
      if ((state_q == ST_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= do_fill ? ST_FILL : ST_RESP;
          end
        end
        ST_FILL: begin
          if (walk_stat.last) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_value_q  <= is_read_q ? mem_rdata : '0;
            out_status_q <= status_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = {1'b0, out_value_q};
  assign m_axis_tuser_o[0] = out_status_q;

endmodule

// File: tb/rectangle_fill_grid_store_checker.sv
module rectangle_fill_grid_store_checker import rfg_pkg::*; #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  // [6:0] row_first, [13:7] col_first, [20:14] row_last, [27:21] col_last,
  // [58:28] new_value
  input  logic [63:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  // [30:0] read_value
  input  logic [31:0] m_axis_tdata_i,
  // [0] status
  input  logic [0:0]  m_axis_tuser_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ValueW-1:0] read_value;
    logic              status;
  } grid_result_t;

  logic [ValueW-1:0] grid_mem [MAX_ROWS*MAX_COLS];
  logic [CountW-1:0] row_cnt;
  logic [CountW-1:0] col_cnt;
  grid_result_t      expected_q [$];

  task automatic flag_error(string msg);
    if (errors_o < 10) $display("%t mismatch: %s", $realtime, msg);
    errors_o++;
  endtask

  // updates the grid copy and returns the result the item should give
  function automatic grid_result_t apply_item(mode_e mode, coord_t r0, coord_t c0,
                                              coord_t r1, coord_t c1,
                                              logic [ValueW-1:0] val);
    grid_result_t res;
    int nr;
    int nc;
    bit ok0;
    bit ok1;
    res = '0;
    nr  = (int'(row_cnt) > MAX_ROWS) ? MAX_ROWS : int'(row_cnt);
    nc  = (int'(col_cnt) > MAX_COLS) ? MAX_COLS : int'(col_cnt);
    ok0 = (int'(r0) < nr) && (int'(c0) < nc);
    ok1 = (int'(r1) < nr) && (int'(c1) < nc);
    case (mode)
      MODE_LOAD: begin
        if (ok0) grid_mem[int'(r0)*MAX_COLS + int'(c0)] = val;
        else res.status = StatusErr;
      end
      MODE_FILL: begin
        if (!ok0 || !ok1) begin
          res.status = StatusErr;
        end else if (r0 <= r1 && c0 <= c1) begin
          for (int r = int'(r0); r <= int'(r1); r++)
            for (int c = int'(c0); c <= int'(c1); c++)
              grid_mem[r*MAX_COLS + c] = val;
        end
      end
      MODE_READ: begin
        if (ok0) res.read_value = grid_mem[int'(r0)*MAX_COLS + int'(c0)];
        else res.status = StatusErr;
      end
      default: res.status = StatusErr;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grid_result_t want;
    grid_result_t got;
    grid_result_t predicted;
    if (!rst_ni) begin
      row_cnt = CountRst;
      col_cnt = CountRst;
      expected_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.read_value = m_axis_tdata_i[ValueW-1:0];
        got.status     = m_axis_tuser_i[0];
        if (expected_q.size() == 0) begin
          flag_error($sformatf("result with none expected: value %h status %b",
                               got.read_value, got.status));
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (got.read_value !== want.read_value)
            flag_error($sformatf("read_value expected %h got %h",
                                 want.read_value, got.read_value));
          if (got.status !== want.status)
            flag_error($sformatf("status expected %b got %b", want.status, got.status));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predicted = apply_item(mode_e'(s_axis_tuser_i),
                               s_axis_tdata_i[6:0], s_axis_tdata_i[13:7],
                               s_axis_tdata_i[20:14], s_axis_tdata_i[27:21],
                               s_axis_tdata_i[58:28]);
        expected_q = {expected_q, predicted};
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ROW_COUNT) row_cnt = cfg_data_i;
        else col_cnt = cfg_data_i;
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// File: tb/rectangle_fill_grid_store_top_tb.sv
module rectangle_fill_grid_store_top_tb;
  import rfg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GridRows  = 128;
  localparam int GridCols  = 128;
  // the worst expected run (a handful of full-grid fills plus long stalls on both
  // sides) stays well below this limit; leave a wide margin
  localparam int CycleLimit = 1_500_000;
  localparam int NumPhases  = 9;
  localparam int BigFillCap = 6;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_idx = 1'b0;
  logic [CountW-1:0]   cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [63:0]         s_tdata = '0;
  logic [1:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [31:0]         m_tdata;
  logic [0:0]          m_tuser;

  int errors;
  int pending;
  int checked;

  // stimulus bookkeeping
  logic [CountW-1:0] cur_rows = CountRst;
  logic [CountW-1:0] cur_cols = CountRst;
  bit  calm = 1'b0;          // no idling on either side while set
  int  sink_hold = 0;
  int  big_fills = 0;
  int  settings_used = 1;
  int  mode_cnt [4] = '{0, 0, 0, 0};
  int  phase_rows [NumPhases] = '{128, 1, 1, 128, 0, 64, 255, 17, 0};
  int  phase_cols [NumPhases] = '{128, 1, 128, 1, 64, 0, 200, 93, 0};
  int  cycle_cnt = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rectangle_fill_grid_store_top #(
    .MAX_ROWS (GridRows),
    .MAX_COLS (GridCols)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  rectangle_fill_grid_store_checker #(
    .MAX_ROWS (GridRows),
    .MAX_COLS (GridCols)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .errors_o        (errors),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // rows/columns actually in use for a count register value
  function automatic int in_use(logic [CountW-1:0] cnt, int max_n);
    return (int'(cnt) > max_n) ? max_n : int'(cnt);
  endfunction

  // mostly in range of the grid in use, sometimes anywhere in the 7-bit field
  function automatic coord_t pick_coord(int n);
    if (n == 0 || $urandom_range(0, 9) == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, n - 1));
  endfunction

  // far edge of a small span, kept inside the grid when the near edge is
  function automatic coord_t span_end(coord_t first, int n);
    int lim;
    int e;
    lim = (n > 0 && int'(first) < n) ? n - 1 : 127;
    e   = int'(first) + $urandom_range(0, 7);
    return coord_t'((e > lim) ? lim : e);
  endfunction

  // sink side: ready drops for random stretches
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      m_tready  <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_tready  <= 1'b1;
      sink_hold <= pick_gap();
    end
  end

  // cycle limit guard
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // present one item and hold it until accepted; entered and left at a posedge
  task automatic push_item(mode_e mode, coord_t r0, coord_t c0, coord_t r1, coord_t c1,
                           logic [ValueW-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, val, c1, r1, c0, r0};
    s_tuser  <= mode;
    mode_cnt[int'(mode)]++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold off the sender until every predicted result has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // both count registers, back to back; only called while idle
  task automatic write_counts(int rows, int cols);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ROW_COUNT;
    cfg_data <= CountW'(rows);
    @(posedge clk);
    cfg_idx  <= CFG_COL_COUNT;
    cfg_data <= CountW'(cols);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_rows = CountW'(rows);
    cur_cols = CountW'(cols);
    settings_used++;
  endtask

  task automatic random_item();
    int sel;
    int nr;
    int nc;
    coord_t r0;
    coord_t c0;
    coord_t r1;
    coord_t c1;
    coord_t t;
    logic [ValueW-1:0] val;
    nr  = in_use(cur_rows, GridRows);
    nc  = in_use(cur_cols, GridCols);
    sel = $urandom_range(0, 99);
    r0  = pick_coord(nr);
    c0  = pick_coord(nc);
    r1  = coord_t'($urandom);
    c1  = coord_t'($urandom);
    val = ValueW'($urandom);
    if (sel < 35) begin
      push_item(MODE_LOAD, r0, c0, r1, c1, val);
    end else if (sel < 60) begin
      if ($urandom_range(0, 99) < 2 && big_fills < BigFillCap) begin
        // rare wide rectangle; the walker visits every cell in it
        big_fills++;
        r1 = pick_coord(nr);
        c1 = pick_coord(nc);
      end else begin
        r1 = span_end(r0, nr);
        c1 = span_end(c0, nc);
        // now and then flip an axis to get a reversed rectangle
        if ($urandom_range(0, 9) == 0) begin
          t = r0; r0 = r1; r1 = t;
        end
        if ($urandom_range(0, 9) == 0) begin
          t = c0; c0 = c1; c1 = t;
        end
      end
      push_item(MODE_FILL, r0, c0, r1, c1, val);
    end else if (sel < 95) begin
      // every cell holds data once the opening full-grid fill is done
      push_item(MODE_READ, r0, c0, r1, c1, val);
    end else begin
      push_item(MODE_RSVD, r0, c0, r1, c1, val);
    end
  endtask

  initial begin
    int n_items;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part, counts at reset value ---
    push_item(MODE_LOAD, 0, 0, 0, 0, 31'h0);
    push_item(MODE_READ, 0, 0, 0, 0, 31'h0);
    push_item(MODE_LOAD, 127, 127, 127, 127, 31'h7FFF_FFFF);
    push_item(MODE_READ, 127, 127, 127, 127, 31'h7FFF_FFFF);
    // whole grid: after this no read can hit an unwritten cell
    push_item(MODE_FILL, 0, 0, 127, 127, 31'h7FFF_FFFF);
    push_item(MODE_READ, 64, 64, 0, 0, 31'h0);
    // single-cell rectangle
    push_item(MODE_FILL, 5, 10, 5, 10, 31'h2AAA_AAAA);
    push_item(MODE_READ, 5, 10, 0, 0, 31'h0);
    // reversed rows, then reversed columns: nothing written, status ok
    push_item(MODE_FILL, 9, 0, 3, 4, 31'h1234_5678);
    push_item(MODE_FILL, 0, 9, 4, 3, 31'h1234_5678);
    push_item(MODE_READ, 5, 3, 0, 0, 31'h0);
    // full-width row and full-height column
    push_item(MODE_FILL, 127, 0, 127, 127, 31'h5555_5555);
    push_item(MODE_FILL, 0, 127, 127, 127, 31'h1);
    push_item(MODE_READ, 127, 64, 0, 0, 31'h0);
    // unused mode with every field bit set
    push_item(MODE_RSVD, 127, 127, 127, 127, 31'h7FFF_FFFF);

    // small grid: each edge one past the end
    wait_idle();
    write_counts(4, 6);
    push_item(MODE_LOAD, 4, 0, 0, 0, 31'h77);
    push_item(MODE_LOAD, 0, 6, 0, 0, 31'h77);
    push_item(MODE_FILL, 0, 0, 3, 6, 31'h66);
    push_item(MODE_FILL, 0, 0, 4, 5, 31'h66);
    push_item(MODE_READ, 4, 0, 0, 0, 31'h0);
    push_item(MODE_FILL, 0, 0, 3, 5, 31'h0ABC_DEF0);
    push_item(MODE_READ, 3, 5, 0, 0, 31'h0);

    // zero rows: everything out of range
    wait_idle();
    write_counts(0, 128);
    push_item(MODE_LOAD, 0, 0, 0, 0, 31'h1);

    // counts above the grid size clamp to it
    wait_idle();
    write_counts(255, 255);
    push_item(MODE_LOAD, 127, 127, 0, 0, 31'h3C3C_3C3C);
    push_item(MODE_READ, 127, 127, 0, 0, 31'h0);

    // --- random phases, one count setting each ---
    phase_rows[NumPhases-1] = $urandom_range(1, 255);
    phase_cols[NumPhases-1] = $urandom_range(1, 255);
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      write_counts(phase_rows[p], phase_cols[p]);
      calm = (p % 3 == 1);
      // a zero count turns every item into an error, so keep those short
      n_items = (phase_rows[p] == 0 || phase_cols[p] == 0) ? 40 : 210;
      repeat (n_items) begin
        if ($urandom_range(0, 199) == 0) wait_idle();
        random_item();
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("stimulus: %0d loads, %0d fills (%0d wide), %0d reads, %0d unused-mode items",
             mode_cnt[0], mode_cnt[1], big_fills, mode_cnt[2], mode_cnt[3]);
    $display("compared %0d results over %0d count settings, %0d mismatches",
             checked, settings_used, errors);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rfg_pkg.sv
sv/rfg_ram.sv
sv/rfg_walk.sv
sv/rectangle_fill_grid_store_top.sv
tb/rectangle_fill_grid_store_checker.sv
tb/rectangle_fill_grid_store_top_tb.sv
